// ===== sv/cpf_pkg.sv =====
package cpf_pkg;

    // Sequencer states of the fusion block
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PMUL,
        ST_ACC,
        ST_USTART,
        ST_UMUL,
        ST_READ,
        ST_RWAIT,
        ST_DIV
    } cpf_state_t;

    // Handshake between the sequencer and a serial arithmetic unit
    typedef struct packed {
        logic start;
    } cpf_unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cpf_unit_rsp_t;

endpackage

// ===== sv/class_probability_fusion.sv =====
// Fuses two class-probability vectors (Q1.F, F = PROB_FRAC_BITS) that arrive
// one class per beat, with last_class on the final class. A beat is taken on
// a clock edge where start is high and busy is low; inputs above 1.0 are
// saturated to 1.0. Each beat stores a*b and adds to running sums; beats past
// MAX_CLASSES are dropped, though a dropped marked beat still closes the
// vector. After the marked beat the block emits one beat per stored class,
// fused_prob = floor(p * 2^F / (sum p + uA*uB + eps)), where uA, uB are one
// minus each vector sum clamped at zero and eps is 1e-6 in Q1.2F. Results
// appear for exactly one cycle with valid high; the receiver cannot stall
// them, so it must take every valid cycle. An input beat occupies the block
// while the bit-serial multiplier (one multiplier bit per cycle) forms a*b.
// A marked beat then runs the multiplier again for the unknown-mass product,
// and each emitted class takes a registered read of the product store and a
// pass of the bit-serial divider (one quotient bit per cycle). busy is low
// again in the cycle that carries the final result.
module class_probability_fusion
    import cpf_pkg::*;
#(
    parameter int MAX_CLASSES    = 16,
    parameter int PROB_FRAC_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] prob_a,
    input  logic [15:0] prob_b,
    input  logic        last_class,
    output logic        valid,
    output logic [15:0] fused_prob,
    output logic [3:0]  class_index,
    output logic        last_out
);

    // Widths
    localparam int AW  = PROB_FRAC_BITS + 1;           // saturated probability
    localparam int SW  = 2 * PROB_FRAC_BITS + 1;       // one product, Q1.2F
    localparam int CW  = $clog2(MAX_CLASSES + 1);      // class count
    localparam int IW  = $clog2(MAX_CLASSES);          // store address
    localparam int SAW = AW + CW;                      // probability sums
    localparam int PSW = SW + CW;                      // product sum
    localparam int DW  = SW + CW + 1;                  // denominator
    localparam int XW  = (AW > 16) ? AW : 16;          // saturation compare

    localparam logic [AW-1:0] ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

    // eps = round(1e-6 * 2^(2F)), at least 1
    localparam longint unsigned EPS_RAW =
        ((64'd1 << (2 * PROB_FRAC_BITS)) + 64'd500000) / 64'd1000000;
    localparam longint unsigned EPS = (EPS_RAW == 0) ? 64'd1 : EPS_RAW;

    cpf_state_t state_reg, state_next;

    logic [AW-1:0]  a_reg, a_next;
    logic [AW-1:0]  b_reg, b_next;
    logic           last_reg, last_next;
    logic [SAW-1:0] sum_a_reg, sum_a_next;
    logic [SAW-1:0] sum_b_reg, sum_b_next;
    logic [PSW-1:0] psum_reg, psum_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [DW-1:0]  den_reg, den_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic           valid_reg, valid_next;
    logic [15:0]    fused_reg, fused_next;
    logic [3:0]     index_reg, index_next;
    logic           last_out_reg, last_out_next;

    // Saturated inputs
    logic [XW-1:0]  a_ext, b_ext;
    logic [AW-1:0]  a_sat, b_sat;

    // Unknown masses
    logic [AW-1:0]  unk_a, unk_b;

    // Sequencer outputs
    logic           mul_sel_unk;
    logic           store_we;
    logic           store_re;
    logic           room;
    logic           final_class;

    cpf_unit_req_t  mul_req, div_req;
    cpf_unit_rsp_t  mul_rsp, div_rsp;
    logic [AW-1:0]  mul_a, mul_b;
    logic [2*AW-1:0] mul_p;
    logic [SW-1:0]  store_rdata;
    logic [PROB_FRAC_BITS-1:0] div_q;

    always_comb
    begin
        a_ext = XW'(prob_a);
        b_ext = XW'(prob_b);
        a_sat = (a_ext > XW'(ONE)) ? ONE : a_ext[AW-1:0];
        b_sat = (b_ext > XW'(ONE)) ? ONE : b_ext[AW-1:0];
        unk_a = (sum_a_reg >= SAW'(ONE)) ? '0 : AW'(SAW'(ONE) - sum_a_reg);
        unk_b = (sum_b_reg >= SAW'(ONE)) ? '0 : AW'(SAW'(ONE) - sum_b_reg);
        room        = (count_reg < CW'(MAX_CLASSES));
        final_class = ((CW'(idx_reg) + CW'(1)) == count_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = last_reg ? ST_USTART : ST_IDLE;
            end
            ST_USTART:
            begin
                state_next = ST_UMUL;
            end
            ST_UMUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = final_class ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        busy          = 1'b1;
        mul_req.start = 1'b0;
        mul_sel_unk   = 1'b0;
        store_we      = 1'b0;
        store_re      = 1'b0;
        div_req.start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy          = 1'b0;
                mul_req.start = start;
            end
            ST_ACC:
            begin
                store_we = room;
            end
            ST_USTART:
            begin
                mul_req.start = 1'b1;
                mul_sel_unk   = 1'b1;
            end
            ST_READ:
            begin
                store_re = 1'b1;
            end
            ST_RWAIT:
            begin
                div_req.start = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign mul_a = mul_sel_unk ? unk_a : a_sat;
    assign mul_b = mul_sel_unk ? unk_b : b_sat;

    // Datapath
    always_comb
    begin
        a_next        = a_reg;
        b_next        = b_reg;
        last_next     = last_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        psum_next     = psum_reg;
        count_next    = count_reg;
        den_next      = den_reg;
        idx_next      = idx_reg;
        valid_next    = 1'b0;
        fused_next    = fused_reg;
        index_next    = index_reg;
        last_out_next = last_out_reg;

        if (state_reg == ST_IDLE && start)
        begin
            a_next    = a_sat;
            b_next    = b_sat;
            last_next = last_class;
        end

        if (state_reg == ST_ACC && room)
        begin
            sum_a_next = sum_a_reg + SAW'(a_reg);
            sum_b_next = sum_b_reg + SAW'(b_reg);
            psum_next  = psum_reg + PSW'(mul_p[SW-1:0]);
            count_next = count_reg + CW'(1);
        end

        if (state_reg == ST_USTART)
        begin
            den_next = DW'(psum_reg) + DW'(EPS);
        end

        if (state_reg == ST_UMUL && mul_rsp.done)
        begin
            den_next = den_reg + DW'(mul_p);
            idx_next = '0;
        end

        if (state_reg == ST_DIV && div_rsp.done)
        begin
            valid_next    = 1'b1;
            fused_next    = 16'(div_q);
            index_next    = 4'(idx_reg);
            last_out_next = final_class;
            if (final_class)
            begin
                // vector closed: start the next one from zero
                sum_a_next = '0;
                sum_b_next = '0;
                psum_next  = '0;
                count_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            psum_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            psum_reg  <= psum_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        last_reg     <= last_next;
        den_reg      <= den_next;
        fused_reg    <= fused_next;
        index_reg    <= index_next;
        last_out_reg <= last_out_next;
    end

    // Shared bit-serial multiplier: a*b per beat, then uA*uB at end of vector
    cpf_mul #(
        .W(AW)
    ) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .a    (mul_a),
        .b    (mul_b),
        .rsp  (mul_rsp),
        .p    (mul_p)
    );

    // Product store, written at the class count, read back in class order
    cpf_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_CLASSES)
    ) u_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(count_reg[IW-1:0]),
        .wdata(mul_p[SW-1:0]),
        .re   (store_re),
        .raddr(idx_reg),
        .rdata(store_rdata)
    );

    // Bit-serial normalizing divider
    cpf_div #(
        .NW(SW),
        .DW(DW),
        .QW(PROB_FRAC_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .num  (store_rdata),
        .den  (den_reg),
        .rsp  (div_rsp),
        .q    (div_q)
    );

    assign valid       = valid_reg;
    assign fused_prob  = fused_reg;
    assign class_index = index_reg;
    assign last_out    = last_out_reg;

`ifndef ASSERT_OFF
    // An accepted beat always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not make block busy");

    // Class count never passes the store depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_CLASSES))
        else $error("class count beyond store depth");

    // Final result frees the block; earlier results keep it busy
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_out |-> !busy && count_reg == '0)
        else $error("block not released after final result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_out |-> busy)
        else $error("block idle in the middle of emission");

    // Results are spaced by at least one divide
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("back-to-back result strobes");
`endif

endmodule

// ===== sv/cpf_ram.sv =====
module cpf_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cpf_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module cpf_mul
    import cpf_pkg::*;
#(
    parameter int W = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cpf_unit_req_t   req,
    input  logic [W-1:0]    a,
    input  logic [W-1:0]    b,
    output cpf_unit_rsp_t   rsp,
    output logic [2*W-1:0]  p
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    mcand_reg, mcand_next;
    logic [2*W-1:0]  acc_reg, acc_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [W:0]      upper;

    always_comb
    begin
        upper      = {1'b0, acc_reg[2*W-1:W]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            mcand_next = a;
            acc_next   = {{W{1'b0}}, b};
            cnt_next   = CNTW'(W);
        end
        else if (cnt_reg != '0)
        begin
            acc_next  = {upper, acc_reg[W-1:1]};
            cnt_next  = cnt_reg - CNTW'(1);
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign p        = acc_reg;

endmodule

// ===== sv/cpf_div.sv =====
// Restoring fraction divider, one quotient bit per cycle: q = floor(num * 2^QW / den).
module cpf_div
    import cpf_pkg::*;
#(
    parameter int NW = 31,
    parameter int DW = 37,
    parameter int QW = 15
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cpf_unit_req_t  req,
    input  logic [NW-1:0]  num,
    input  logic [DW-1:0]  den,
    output cpf_unit_rsp_t  rsp,
    output logic [QW-1:0]  q
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic [DW:0]     shifted;
    logic [DW:0]     diff;
    logic            ge;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, den_reg};
        ge        = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = DW'(num);
            den_next = den;
            q_next   = '0;
            cnt_next = CNTW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[DW-1:0] : shifted[DW-1:0];
            q_next    = {q_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - CNTW'(1);
            done_next = (cnt_reg == CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign q        = q_reg;

endmodule
